[rtl/baseband_header_inserter_assert.svh]
// Assertion macros for the baseband header inserter.
// Used by baseband_header_inserter.sv; needs signals clk and arst_n in scope.
`ifndef BASEBAND_HEADER_INSERTER_ASSERT_SVH
`define BASEBAND_HEADER_INSERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define BHI_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("bhi assertion failed");
`define BHI_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("bhi assertion failed");
`else
`define BHI_ASSERT_IMP(lbl, a, c)
`define BHI_ASSERT_NXT(lbl, a, c)
`endif
`endif

[rtl/bhi_pkg.sv]
// Package for the baseband header inserter: payload structs, constants, CRC-8.
// No dependencies.
package bhi_pkg;
	typedef struct packed {
		logic [1:0] stream_id;
		logic [7:0] ts_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_bits;
		logic [3:0] bit_count;
		logic       is_header;
		logic       sync_error;
		logic       last;
	} result_t;

	localparam logic [7:0]  SYNC_BYTE  = 8'h47;
	localparam logic [7:0]  PKT_LEN    = 8'd188;
	localparam logic [15:0] UPL_BITS   = 16'd1504;
	localparam logic [7:0]  TS_CRC_GEN = 8'hD5;
	localparam logic [15:0] DFL_RESET  = 16'd32128;
	localparam int          HDR_LEN    = 10;

	localparam logic [2:0] REG_NUM_STREAMS = 3'd0;
	localparam logic [2:0] REG_ROLLOFF     = 3'd1;
	localparam logic [2:0] REG_MEDIUM      = 3'd2;
	localparam logic [2:0] REG_FIELD_S0    = 3'd3;
	localparam logic [2:0] REG_FIELD_S1    = 3'd4;
	localparam logic [2:0] REG_FIELD_S2    = 3'd5;
	localparam logic [2:0] REG_FIELD_S3    = 3'd6;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ TS_CRC_GEN) : (c << 1);
		end
		return c;
	endfunction
endpackage

[rtl/baseband_header_inserter.sv]
// Baseband header inserter for up to STREAMS transport streams (DVB-S2 mode adaptation).
// Uses bhi_pkg and baseband_header_inserter_assert.svh.
//
// Usage: transport bytes tagged with a stream number arrive on the item channel
// (item_valid/item_ready). Each accepted byte yields 1 to 12 transfers on the result
// channel (res_valid/res_ready): an optional 10-byte baseband header and an optional
// held low nibble, in either order, then the byte itself (or its high nibble when the
// data field fills). res.last marks the final transfer of each byte. A stream number
// at or above STREAMS is taken and dropped.
// Latency: first result is presented the cycle after the byte is taken.
// Throughput: one byte per cycle when it causes a single result and res_ready stays high;
// otherwise the byte holds the channel until all its results are out, one per cycle while
// res_ready is high. The next byte is taken in the same cycle as the last result of the
// previous one, so the result register is the only buffer.
// Reset: all per-stream state clears (roll-off phase set), registers take their
// defaults, and the first byte of every stream opens a new data field.
// Receiver stall: res_ready low holds the current result; item_ready drops until
// the final result of the pending byte is transferred.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) apply from the next field opened.
`include "baseband_header_inserter_assert.svh"

module baseband_header_inserter
	import bhi_pkg::*;
#(
	parameter int STREAMS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        res_valid,
	input  logic        res_ready,
	output result_t     res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	localparam int SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

	logic [2:0]  num_streams_q;
	logic [2:0]  rolloff_q;
	logic [3:0]  medium_mask_q;
	logic [15:0] field_bits_q [4];

	logic [7:0]  pos_q   [STREAMS];
	logic [7:0]  pcrc_q  [STREAMS];
	logic [15:0] left_q  [STREAMS];
	logic        pend_q  [STREAMS];
	logic [3:0]  snib_q  [STREAMS];
	logic        phase_q [STREAMS];

	logic        busy_q;
	logic [3:0]  cnt_q;
	logic [3:0]  last_idx_q;
	logic        hdr_s1, hdra_s1, nib_s1, dat8_s1, serr_s1;
	logic [3:0]  nibv_s1;
	logic [7:0]  dat_s1;
	logic [9:0][7:0] hbytes_s1;

	logic [SW-1:0] sidx;
	logic          sok, take, load, res_xfer, res_last;
	logic [15:0]   dfl, cap, left, lefta, left1, left2, left3, syncd;
	logic          pend, hdr_a, hdr_b, hdr, multi, nib_mode, phase_n;
	logic [1:0]    ro;
	logic [7:0]    pos, data, crc_n, hcrc;
	logic          serr;
	logic [9:0][7:0] hb;

	always_comb begin
		sidx     = SW'({30'd0, item.stream_id});
		sok      = {30'd0, item.stream_id} < STREAMS;
		dfl      = field_bits_q[item.stream_id];
		nib_mode = medium_mask_q[item.stream_id];
		cap      = nib_mode ? (dfl & 16'hFFFC) : (dfl & 16'hFFF8);
		if (cap < 16'd8) begin
			cap = 16'd8;
		end
		multi = num_streams_q > 3'd1;
		left  = left_q[sidx];
		pend  = pend_q[sidx];
		pos   = pos_q[sidx];
		hdr_a = pend && (left < 16'd4);
		lefta = hdr_a ? cap : left;
		left1 = pend ? (lefta - 16'd4) : left;
		hdr_b = left1 < 16'd4;
		left2 = hdr_b ? cap : left1;
		hdr   = hdr_a || hdr_b;

		phase_n = phase_q[sidx];
		ro      = rolloff_q[1:0];
		if (rolloff_q[2]) begin
			if (phase_q[sidx]) begin
				ro = 2'd3;
			end
			if (hdr) begin
				phase_n = !phase_q[sidx];
			end
		end

		syncd = (pos == 8'd0) ? 16'd0 : (16'(PKT_LEN) - 16'(pos)) << 3;
		if (hdr_a) begin
			syncd = syncd + 16'd4;
		end

		hb[0] = {2'b11, multi ? 2'b00 : 2'b11, 2'b00, ro};
		hb[1] = multi ? {6'd0, item.stream_id} : 8'd0;
		hb[2] = UPL_BITS[15:8];
		hb[3] = UPL_BITS[7:0];
		hb[4] = dfl[15:8];
		hb[5] = dfl[7:0];
		hb[6] = SYNC_BYTE;
		hb[7] = syncd[15:8];
		hb[8] = syncd[7:0];
		hcrc = 8'd0;
		for (int k = 0; k < HDR_LEN - 1; k++) begin
			hcrc = crc8_byte(hcrc, hb[k]);
		end
		hb[9] = hcrc;

		if (pos == 8'd0) begin
			serr  = item.ts_byte != SYNC_BYTE;
			data  = pcrc_q[sidx];
			crc_n = 8'd0;
		end else begin
			serr  = 1'b0;
			data  = item.ts_byte;
			crc_n = crc8_byte(pcrc_q[sidx], item.ts_byte);
		end
		left3 = (left2 >= 16'd8) ? (left2 - 16'd8) : (left2 - 16'd4);
	end

	always_comb begin
		logic [3:0] hoff, nibpos, hidx;
		hoff   = hdra_s1 ? 4'd0 : (nib_s1 ? 4'd1 : 4'd0);
		nibpos = hdra_s1 ? 4'd10 : 4'd0;
		hidx   = cnt_q - hoff;
		res_last = cnt_q == last_idx_q;
		res = '0;
		res.last = res_last;
		if (hdr_s1 && cnt_q >= hoff && cnt_q < hoff + 4'd10) begin
			res.out_bits  = hbytes_s1[hidx];
			res.bit_count = 4'd8;
			res.is_header = 1'b1;
		end else if (nib_s1 && cnt_q == nibpos) begin
			res.out_bits  = {4'd0, nibv_s1};
			res.bit_count = 4'd4;
		end else begin
			res.out_bits   = dat8_s1 ? dat_s1 : {4'd0, dat_s1[7:4]};
			res.bit_count  = dat8_s1 ? 4'd8 : 4'd4;
			res.sync_error = serr_s1;
		end
	end

	assign res_valid  = busy_q;
	assign res_xfer   = res_valid && res_ready;
	assign item_ready = !busy_q || (res_ready && res_last);
	assign take       = item_valid && item_ready;
	assign load       = take && sok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_streams_q <= 3'd1;
			rolloff_q     <= 3'd0;
			medium_mask_q <= 4'd0;
			for (int i = 0; i < 4; i++) begin
				field_bits_q[i] <= DFL_RESET;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_STREAMS: num_streams_q   <= cfg_wdata[2:0];
				REG_ROLLOFF:     rolloff_q       <= cfg_wdata[2:0];
				REG_MEDIUM:      medium_mask_q   <= cfg_wdata[3:0];
				REG_FIELD_S0:    field_bits_q[0] <= cfg_wdata;
				REG_FIELD_S1:    field_bits_q[1] <= cfg_wdata;
				REG_FIELD_S2:    field_bits_q[2] <= cfg_wdata;
				REG_FIELD_S3:    field_bits_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STREAMS; i++) begin
				pos_q[i]   <= 8'd0;
				pcrc_q[i]  <= 8'd0;
				left_q[i]  <= 16'd0;
				pend_q[i]  <= 1'b0;
				snib_q[i]  <= 4'd0;
				phase_q[i] <= 1'b1;
			end
		end else if (load) begin
			pos_q[sidx]   <= (pos == PKT_LEN - 8'd1) ? 8'd0 : pos + 8'd1;
			pcrc_q[sidx]  <= crc_n;
			left_q[sidx]  <= left3;
			pend_q[sidx]  <= left2 < 16'd8;
			phase_q[sidx] <= phase_n;
			if (left2 < 16'd8) begin
				snib_q[sidx] <= data[3:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else if (take) begin
			busy_q <= sok;
			cnt_q  <= 4'd0;
		end else if (res_xfer) begin
			if (res_last) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hdr_s1     <= hdr;
			hdra_s1    <= hdr_a;
			nib_s1     <= pend;
			nibv_s1    <= snib_q[sidx];
			hbytes_s1  <= hb;
			dat_s1     <= data;
			dat8_s1    <= left2 >= 16'd8;
			serr_s1    <= serr;
			last_idx_q <= (hdr ? 4'd10 : 4'd0) + (pend ? 4'd1 : 4'd0);
		end
	end

	`BHI_ASSERT_IMP(a_cnt_range, busy_q, cnt_q <= last_idx_q)
	`BHI_ASSERT_NXT(a_stay_busy, res_xfer && !res_last, busy_q)
	`BHI_ASSERT_IMP(a_take_free, take, !busy_q || res_xfer)
	`BHI_ASSERT_IMP(a_hdr_noerr, res_valid, !(res.is_header && res.sync_error))
endmodule

[tb/baseband_header_inserter_test.sv]
// Testbench for baseband_header_inserter: drives tagged transport bytes, predicts
// header, nibble and byte transfers per stream and checks them in order.
// Depends on bhi_pkg and the baseband_header_inserter RTL.
module baseband_header_inserter_test;
	import bhi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	result_t     res;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	baseband_header_inserter #(.STREAMS(4)) dut (.*);

	always #1 clk = ~clk;

	// shadow registers and per-stream state
	logic [2:0]  num_streams_q;
	logic [2:0]  rolloff_q;
	logic [3:0]  medium_q;
	logic [15:0] dfl_q [4];
	logic [7:0]  pkt_pos [4];
	logic [7:0]  pkt_crc [4];
	logic [15:0] bits_left [4];
	logic        nib_held [4];
	logic [3:0]  nib_saved [4];
	logic        ro_phase [4];

	result_t expected_transfers [$];
	int      errors = 0;
	bit      rx_noidle = 1'b0;
	bit      tx_noidle = 1'b0;
	int      hold_req = 0;
	int      hold_seen = 0;
	int      hold_cnt = 0;

	function automatic logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++)
			c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
		return c;
	endfunction

	function automatic result_t mk(logic [7:0] b, logic [3:0] n, logic h, logic e);
		result_t r;
		r.out_bits = b;
		r.bit_count = n;
		r.is_header = h;
		r.sync_error = e;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic open_field(int s);
		logic [7:0]  h [10];
		logic        nib_mode;
		logic [15:0] cap;
		logic [1:0]  ro;
		logic [15:0] syncd;
		logic [7:0]  crc;
		logic        multi;
		nib_mode = medium_q[s];
		cap = nib_mode ? (dfl_q[s] & 16'hFFFC) : (dfl_q[s] & 16'hFFF8);
		if (cap < 16'd8) cap = 16'd8;
		multi = num_streams_q > 3'd1;
		if (rolloff_q[2]) begin
			ro = ro_phase[s] ? 2'd3 : rolloff_q[1:0];
			ro_phase[s] = ~ro_phase[s];
		end else begin
			ro = rolloff_q[1:0];
		end
		syncd = (pkt_pos[s] == 8'd0) ? 16'd0 : (16'(PKT_LEN) - 16'(pkt_pos[s])) * 16'd8;
		if (nib_held[s]) syncd += 16'd4;
		h[0] = 8'hC0 | (multi ? 8'h00 : 8'h30) | 8'(ro);
		h[1] = multi ? 8'(s) : 8'h00;
		h[2] = UPL_BITS[15:8];
		h[3] = UPL_BITS[7:0];
		h[4] = dfl_q[s][15:8];
		h[5] = dfl_q[s][7:0];
		h[6] = SYNC_BYTE;
		h[7] = syncd[15:8];
		h[8] = syncd[7:0];
		crc = 8'h00;
		for (int k = 0; k < 9; k++) crc = crc_step(crc, h[k]);
		h[9] = crc;
		for (int k = 0; k < 10; k++) expected_transfers.push_back(mk(h[k], 4'd8, 1'b1, 1'b0));
		bits_left[s] = cap;
	endtask

	task automatic predict_byte(item_t it);
		int         s;
		logic [7:0] data;
		logic       serr;
		result_t    t;
		s = int'(it.stream_id);
		serr = 1'b0;
		if (nib_held[s]) begin
			if (bits_left[s] < 16'd4) open_field(s);
			expected_transfers.push_back(mk({4'h0, nib_saved[s]}, 4'd4, 1'b0, 1'b0));
			bits_left[s] = bits_left[s] >= 16'd4 ? bits_left[s] - 16'd4 : 16'd0;
			nib_held[s] = 1'b0;
		end
		if (bits_left[s] < 16'd4) open_field(s);
		if (pkt_pos[s] == 8'd0) begin
			serr = it.ts_byte != SYNC_BYTE;
			data = pkt_crc[s];
			pkt_crc[s] = 8'h00;
		end else begin
			data = it.ts_byte;
			pkt_crc[s] = crc_step(pkt_crc[s], it.ts_byte);
		end
		pkt_pos[s] = (pkt_pos[s] == PKT_LEN - 8'd1) ? 8'd0 : pkt_pos[s] + 8'd1;
		if (bits_left[s] >= 16'd8) begin
			expected_transfers.push_back(mk(data, 4'd8, 1'b0, serr));
			bits_left[s] -= 16'd8;
		end else begin
			expected_transfers.push_back(mk({4'h0, data[7:4]}, 4'd4, 1'b0, serr));
			nib_saved[s] = data[3:0];
			nib_held[s] = 1'b1;
			bits_left[s] -= 16'd4;
		end
		t = expected_transfers.pop_back();
		t.last = 1'b1;
		expected_transfers.push_back(t);
	endtask

	task automatic send_byte(logic [1:0] s, logic [7:0] b);
		item_t it;
		it.stream_id = s;
		it.ts_byte = b;
		while (!tx_noidle && $urandom_range(99) < 30) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		predict_byte(it);
		@(negedge clk);
	endtask

	// result side: stall at random, long hold-off on request
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			res_ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt <= 300;
			res_ready <= 1'b0;
		end else begin
			res_ready <= rx_noidle || ($urandom_range(99) >= 30);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (expected_transfers.size() == 0) begin
				$error("unexpected transfer %p", res);
				errors++;
			end else begin
				result_t e;
				e = expected_transfers.pop_front();
				if (res.out_bits !== e.out_bits) begin
					$error("out_bits exp %h got %h", e.out_bits, res.out_bits); errors++;
				end
				if (res.bit_count !== e.bit_count) begin
					$error("bit_count exp %0d got %0d", e.bit_count, res.bit_count); errors++;
				end
				if (res.is_header !== e.is_header) begin
					$error("is_header exp %b got %b", e.is_header, res.is_header); errors++;
				end
				if (res.sync_error !== e.sync_error) begin
					$error("sync_error exp %b got %b", e.sync_error, res.sync_error); errors++;
				end
				if (res.last !== e.last) begin
					$error("last exp %b got %b", e.last, res.last); errors++;
				end
			end
		end
	end

	task automatic drain();
		item_valid <= 1'b0;
		while (expected_transfers.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_NUM_STREAMS: num_streams_q = val[2:0];
			REG_ROLLOFF:     rolloff_q = val[2:0];
			REG_MEDIUM:      medium_q = val[3:0];
			default:         dfl_q[idx - REG_FIELD_S0] = val;
		endcase
	endtask

	// one packet-shaped run of bytes on a stream, starting at its current position
	task automatic send_packet_bytes(logic [1:0] s, int count, bit bad_sync);
		for (int k = 0; k < count; k++) begin
			if (pkt_pos[s] == 8'd0)
				send_byte(s, bad_sync ? 8'($urandom_range(255)) : SYNC_BYTE);
			else
				send_byte(s, 8'($urandom));
		end
	endtask

	task automatic test_directed();
		send_byte(2'd0, SYNC_BYTE);
		send_byte(2'd0, 8'h00);
		send_byte(2'd0, 8'hFF);
		send_byte(2'd1, 8'h00);
		send_byte(2'd2, 8'hFF);
		send_byte(2'd3, SYNC_BYTE);
		drain();
		write_reg(REG_NUM_STREAMS, 16'd4);
		write_reg(REG_ROLLOFF, 16'd7);
		write_reg(REG_MEDIUM, 16'hF);
		write_reg(REG_FIELD_S0, 16'd0);
		write_reg(REG_FIELD_S1, 16'd12);
		write_reg(REG_FIELD_S2, 16'd20);
		write_reg(REG_FIELD_S3, 16'hFFFF);
		for (int k = 0; k < 4; k++) send_byte(2'(k), 8'hA5);
		for (int k = 0; k < 4; k++) send_byte(2'(k), 8'h5A);
		send_byte(2'd1, 8'h3C);
		send_byte(2'd2, 8'hC3);
		drain();
		write_reg(REG_MEDIUM, 16'h0);
		send_byte(2'd1, 8'h81);
		send_byte(2'd2, 8'h18);
		drain();
	endtask

	task automatic test_full_packets();
		write_reg(REG_NUM_STREAMS, 16'd1);
		write_reg(REG_ROLLOFF, 16'd4);
		write_reg(REG_FIELD_S0, 16'd58112);
		write_reg(REG_FIELD_S1, 16'd404);
		write_reg(REG_MEDIUM, 16'b0010);
		rx_noidle = 1'b1;
		tx_noidle = 1'b1;
		while (pkt_pos[0] != 8'd0) send_byte(2'd0, 8'($urandom));
		send_packet_bytes(2'd0, 3, 1'b0);
		send_packet_bytes(2'd1, 6, 1'b1);
		drain();
		rx_noidle = 1'b0;
		tx_noidle = 1'b0;
	endtask

	task automatic test_stall_fill();
		hold_req++;
		for (int k = 0; k < 12; k++) send_byte(2'($urandom_range(3)), 8'($urandom));
		drain();
	endtask

	task automatic test_random(int n);
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_NUM_STREAMS, 16'($urandom_range(7)));
			write_reg(REG_ROLLOFF, 16'($urandom_range(7)));
			write_reg(REG_MEDIUM, 16'($urandom_range(15)));
			for (int s = 0; s < 4; s++)
				write_reg(3'(REG_FIELD_S0 + s), ($urandom_range(3) == 0) ?
					16'($urandom) : 16'($urandom_range(8, 120)));
			rx_noidle = (ph == 2);
			tx_noidle = (ph == 2);
			for (int k = 0; k < n / 4; k++) begin
				if ($urandom_range(9) == 0)
					send_byte(2'($urandom_range(3)), 8'($urandom));
				else
					send_packet_bytes(2'($urandom_range(3)), 1, $urandom_range(7) == 0);
			end
			drain();
		end
		rx_noidle = 1'b0;
		tx_noidle = 1'b0;
	endtask

	initial begin
		num_streams_q = 3'd1;
		rolloff_q = 3'd0;
		medium_q = 4'd0;
		for (int s = 0; s < 4; s++) begin
			dfl_q[s] = DFL_RESET;
			pkt_pos[s] = '0;
			pkt_crc[s] = '0;
			bits_left[s] = '0;
			nib_held[s] = 1'b0;
			nib_saved[s] = '0;
			ro_phase[s] = 1'b1;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_full_packets();
		test_stall_fill();
		test_random(24);
		drain();
		repeat (20) @(negedge clk);
		if (errors == 0 && expected_transfers.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end
endmodule
